@@ design/bole_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned ItemPosW = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_INS_FIRST = 3'd0,
    FUNC_INS_LAST  = 3'd1,
    FUNC_INS_POS   = 3'd2,
    FUNC_DEL_FIRST = 3'd3,
    FUNC_DEL_LAST  = 3'd4,
    FUNC_DEL_POS   = 3'd5,
    FUNC_READ      = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Per-cycle command broadcast along the cell chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_READ
  } state_e;

endpackage

@@ design/bole_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_cell
// One list slot. Holds a value and takes a neighbor's value, the insert
// value or the head value according to the broadcast command.
// ----------------------------------------------------------------------------
module bole_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 4
) (
  input  logic                                clk_i,
  input  bole_pkg::cmd_e                      cmd_i,
  input  logic [IdxW-1:0]                     idx_i,
  input  logic [IdxW-1:0]                     last_idx_i,
  input  logic signed [bole_pkg::ValueW-1:0]  ins_val_i,
  input  logic signed [bole_pkg::ValueW-1:0]  head_val_i,
  input  logic signed [bole_pkg::ValueW-1:0]  left_val_i,
  input  logic signed [bole_pkg::ValueW-1:0]  right_val_i,
  output logic signed [bole_pkg::ValueW-1:0]  val_o
);
  import bole_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic signed [ValueW-1:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (MyIdx > idx_i) begin
          val_d = left_val_i;
        end else if (MyIdx == idx_i) begin
          val_d = ins_val_i;
        end
      end
      CMD_DELETE: begin
        if (MyIdx >= idx_i) begin
          val_d = right_val_i;
        end
      end
      CMD_ROTATE: begin
        // head wraps to the tail slot
        val_d = (MyIdx == last_idx_i) ? head_val_i : right_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ design/bounded_ordered_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of up to CAPACITY signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// Inserts and deletes shift the whole cell chain at once: the input is
// taken and its single status transfer is offered in the next cycle.
// A read out of N values rotates the chain one slot per output transfer,
// giving one transfer per cycle while out_ready_i is high; after the last
// value the list is back in order.
// Only one item is in flight at a time.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bole_pkg::FuncW-1:0]          func_i,
  input  logic signed [bole_pkg::ValueW-1:0]  value_i,
  input  logic [bole_pkg::PosW-1:0]           position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [bole_pkg::ValueW-1:0]  item_value_o,
  output logic [bole_pkg::ItemPosW-1:0]       item_position_o,
  output logic                                last_o
);
  import bole_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  status_e             status_q, status_d;
  logic [CntW-1:0]     rd_pos_q, rd_pos_d;

  cmd_e                cmd;
  logic [IdxW-1:0]     idx;
  logic [IdxW-1:0]     last_idx;
  status_e             dec_status;
  logic                dec_read;
  logic                in_xfer, out_xfer, rd_last;
  logic [PosW:0]       pos_ext, cnt_ext;

  logic signed [ValueW-1:0] cell_val [CAPACITY];

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;
  assign pos_ext  = {1'b0, position_i};
  assign cnt_ext  = (PosW + 1)'(count_q);
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign rd_last  = (rd_pos_q == count_q);

  // Operation decode
  always_comb begin
    cmd        = CMD_HOLD;
    idx        = '0;
    dec_status = ST_OK;
    dec_read   = 1'b0;
    if (state_q == S_READ) begin
      if (out_ready_i) begin
        cmd = CMD_ROTATE;
      end
    end else if (in_xfer) begin
      case (func_i)
        FUNC_INS_FIRST, FUNC_INS_LAST: begin
          if (count_q == CntW'(CAPACITY)) begin
            dec_status = ST_FULL;
          end else begin
            cmd = CMD_INSERT;
            idx = (func_i == FUNC_INS_FIRST) ? '0 : IdxW'(count_q);
          end
        end
        FUNC_INS_POS: begin
          if (position_i == '0 || pos_ext > cnt_ext + (PosW + 1)'(1)) begin
            dec_status = ST_INVALID;
          end else if (count_q == CntW'(CAPACITY)) begin
            dec_status = ST_FULL;
          end else begin
            cmd = CMD_INSERT;
            idx = IdxW'(position_i - PosW'(1));
          end
        end
        FUNC_DEL_FIRST, FUNC_DEL_LAST: begin
          if (count_q == '0) begin
            dec_status = ST_EMPTY;
          end else begin
            cmd = CMD_DELETE;
            idx = (func_i == FUNC_DEL_FIRST) ? '0 : last_idx;
          end
        end
        FUNC_DEL_POS: begin
          if (count_q == '0) begin
            dec_status = ST_EMPTY;
          end else if (position_i == '0 || pos_ext > cnt_ext) begin
            dec_status = ST_INVALID;
          end else begin
            cmd = CMD_DELETE;
            idx = IdxW'(position_i - PosW'(1));
          end
        end
        FUNC_READ: begin
          if (count_q == '0) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_read = 1'b1;
          end
        end
        default: dec_status = ST_INVALID;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    rd_pos_d = rd_pos_q;
    count_d  = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d = dec_status;
          rd_pos_d = CntW'(1);
          state_d  = dec_read ? S_READ : S_RESP;
        end
      end
      S_RESP: begin
        if (out_xfer) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_xfer) begin
          rd_pos_d = rd_pos_q + CntW'(1);
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd == CMD_INSERT) begin
      count_d = count_q + CntW'(1);
    end else if (cmd == CMD_DELETE) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Outputs
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    status_o        = ST_OK;
    item_value_o    = '0;
    item_position_o = '0;
    last_o          = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        status_o    = status_q;
        last_o      = 1'b1;
      end
      S_READ: begin
        out_valid_o     = 1'b1;
        item_value_o    = cell_val[0];
        item_position_o = ItemPosW'(rd_pos_q);
        last_o          = rd_last;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_OK;
      rd_pos_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      rd_pos_q <= rd_pos_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_val, right_val;
    if (i == 0) begin : g_head
      assign left_val = cell_val[i];
    end else begin : g_body
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    bole_cell #(
      .Index(i),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .idx_i      (idx),
      .last_idx_i (last_idx),
      .ins_val_i  (value_i),
      .head_val_i (cell_val[0]),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .val_o      (cell_val[i])
    );
  end

endmodule
